@@ rtl/tmcr_pkg.sv @@
// ----------------------------------------------------------------------------
// tmcr_pkg
// Shared types and constants for the tile map collision resolver: command
// and register codes, controller states, and the command and status words
// between controller and datapath.
// ----------------------------------------------------------------------------
package tmcr_pkg;

  // default number of one-bit map entries
  localparam int MAP_TILES_DEF = 65536;

  // tile edge in pixels; floor division by it is a drop of the low bits
  localparam int TILE_SIZE  = 8;
  localparam int TILE_SHIFT = $clog2(TILE_SIZE);

  // field widths
  localparam int PX_W   = 16;
  localparam int DIM_W  = 8;
  localparam int MOVE_W = 8;
  localparam int IDX_W  = 16;
  localparam int CMD_W  = 2;
  localparam int CFG_W  = 8;

  // signed tile coordinate width
  localparam int TC_W = PX_W - TILE_SHIFT;

  // input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_OVERLAP = 2'd1,
    CMD_MOVE    = 2'd2
  } cmd_t;

  // configuration register indexes
  typedef enum logic {
    CFG_MAP_WIDTH  = 1'b0,
    CFG_MAP_HEIGHT = 1'b1
  } cfg_reg_t;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_AXIS,
    S_PROBE,
    S_CHECK,
    S_SCAN,
    S_ADV,
    S_AXEND,
    S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear_run;
    logic mem_write;
    logic axis_init;
    logic probe;
    logic scan_load;
    logic scan_run;
    logic advance;
    logic axis_end;
    logic set_ov;
    logic result_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic ov_mode;
    logic axis_y;
    logic delta_zero;
    logic last_step;
    logic empty;
    logic outside;
    logic cached;
    logic hit;
    logic issue_done;
    logic pend;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/tile_map_collision_resolver.sv @@
// ----------------------------------------------------------------------------
// tile_map_collision_resolver
// One-bit solid tile map with rectangle overlap queries and an X-then-Y
// pixel sweep that stops each axis before the first colliding position.
//
//   channel  direction  handshake           word
//   in_      in         in_valid/in_stall   command, tile, rectangle, move
//   out_     out        out_valid/out_stall overlaps, achieved_x, achieved_y
//   cfg_     in         cfg_valid/cfg_ready index 0 map width, 1 map height
//
// A tile write produces no result; command 3 is taken and does nothing. A
// rectangle probe reads each in-map tile from the single map read port,
// skipped when the range is empty, off the map, or equal to the last range
// found free. A move runs one probe per pixel step on each axis, and the
// result register frees the input. After reset a clearing pass writes the
// map once, input stalled. A stalled result holds its word; the next item
// may run meanwhile.
// ----------------------------------------------------------------------------
module tile_map_collision_resolver #(
  parameter int MAP_TILES = tmcr_pkg::MAP_TILES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tmcr_pkg::CMD_W-1:0]         in_command,
  input  logic [tmcr_pkg::IDX_W-1:0]         in_tile_index,
  input  logic                               in_tile_solid,
  input  logic signed [tmcr_pkg::PX_W-1:0]   in_left_px,
  input  logic signed [tmcr_pkg::PX_W-1:0]   in_top_px,
  input  logic [tmcr_pkg::DIM_W-1:0]         in_width_px,
  input  logic [tmcr_pkg::DIM_W-1:0]         in_height_px,
  input  logic signed [tmcr_pkg::MOVE_W-1:0] in_move_x,
  input  logic signed [tmcr_pkg::MOVE_W-1:0] in_move_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_overlaps,
  output logic signed [tmcr_pkg::MOVE_W-1:0] out_achieved_x,
  output logic signed [tmcr_pkg::MOVE_W-1:0] out_achieved_y,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [tmcr_pkg::CFG_W-1:0]         cfg_data
);

  tmcr_pkg::dp_cmd_t  cmd;
  tmcr_pkg::dp_stat_t st;

  tmcr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .st         (st),
    .cmd        (cmd)
  );

  tmcr_dp #(
    .MAP_TILES (MAP_TILES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_command     (in_command),
    .in_tile_index  (in_tile_index),
    .in_tile_solid  (in_tile_solid),
    .in_left_px     (in_left_px),
    .in_top_px      (in_top_px),
    .in_width_px    (in_width_px),
    .in_height_px   (in_height_px),
    .in_move_x      (in_move_x),
    .in_move_y      (in_move_y),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_overlaps   (out_overlaps),
    .out_achieved_x (out_achieved_x),
    .out_achieved_y (out_achieved_y)
  );

  // no item taken while the map is being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_run |-> in_stall)
    else $error("item accepted during clearing pass");

  // a new result never overwrites one still waiting
  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending word");

  // a tile write produces no result
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_command == tmcr_pkg::CMD_WRITE)) |=>
      !$rose(out_valid))
    else $error("result produced by a tile write");

  // map reads are issued only after the range was taken in range
  a_scan_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_load |=> !st.pend)
    else $error("stale map read after scan start");

endmodule

@@ rtl/tmcr_ram.sv @@
// ----------------------------------------------------------------------------
// tmcr_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tmcr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];

  // write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ rtl/tmcr_ctrl.sv @@
// ----------------------------------------------------------------------------
// tmcr_ctrl
// Controller: sequences the clearing pass, tile writes, rectangle probes,
// the per-axis pixel sweep and the result hand-off.
// ----------------------------------------------------------------------------
module tmcr_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [tmcr_pkg::CMD_W-1:0]    in_command,
  output logic                          in_stall,
  input  tmcr_pkg::dp_stat_t            st,
  output tmcr_pkg::dp_cmd_t             cmd
);

  tmcr_pkg::state_t state_r, state_nxt;
  logic             free_w;
  logic             hit_w;

  // state register, clearing pass first after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmcr_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // probe outcome, from the range check or from the tile scan
  always_comb begin
    free_w = 1'b0;
    hit_w  = 1'b0;
    if (state_r == tmcr_pkg::S_CHECK) begin
      free_w = st.empty || (!st.outside && st.cached);
      hit_w  = !st.empty && st.outside;
    end else if (state_r == tmcr_pkg::S_SCAN) begin
      hit_w  = st.hit;
      free_w = !st.hit && st.issue_done && !st.pend;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tmcr_pkg::S_CLEAR: begin
        if (st.clear_done) state_nxt = tmcr_pkg::S_IDLE;
      end
      tmcr_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            tmcr_pkg::CMD_WRITE:   state_nxt = tmcr_pkg::S_WRITE;
            tmcr_pkg::CMD_OVERLAP: state_nxt = tmcr_pkg::S_PROBE;
            tmcr_pkg::CMD_MOVE:    state_nxt = tmcr_pkg::S_AXIS;
            default:               state_nxt = tmcr_pkg::S_IDLE;
          endcase
        end
      end
      tmcr_pkg::S_WRITE: state_nxt = tmcr_pkg::S_IDLE;
      tmcr_pkg::S_AXIS: begin
        state_nxt = st.delta_zero ? tmcr_pkg::S_AXEND : tmcr_pkg::S_PROBE;
      end
      tmcr_pkg::S_PROBE: state_nxt = tmcr_pkg::S_CHECK;
      tmcr_pkg::S_CHECK, tmcr_pkg::S_SCAN: begin
        if (hit_w) begin
          state_nxt = st.ov_mode ? tmcr_pkg::S_RESULT : tmcr_pkg::S_AXEND;
        end else if (free_w) begin
          state_nxt = st.ov_mode ? tmcr_pkg::S_RESULT : tmcr_pkg::S_ADV;
        end else begin
          state_nxt = tmcr_pkg::S_SCAN;
        end
      end
      tmcr_pkg::S_ADV: begin
        state_nxt = st.last_step ? tmcr_pkg::S_AXEND : tmcr_pkg::S_PROBE;
      end
      tmcr_pkg::S_AXEND: begin
        state_nxt = st.axis_y ? tmcr_pkg::S_RESULT : tmcr_pkg::S_AXIS;
      end
      tmcr_pkg::S_RESULT: begin
        if (st.out_free) state_nxt = tmcr_pkg::S_IDLE;
      end
      default: state_nxt = tmcr_pkg::S_CLEAR;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      tmcr_pkg::S_CLEAR: cmd.clear_run = 1'b1;
      tmcr_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      tmcr_pkg::S_WRITE: cmd.mem_write = 1'b1;
      tmcr_pkg::S_AXIS:  cmd.axis_init = 1'b1;
      tmcr_pkg::S_PROBE: cmd.probe = 1'b1;
      tmcr_pkg::S_CHECK: begin
        cmd.scan_load = !st.empty && !st.outside && !st.cached;
        cmd.set_ov    = hit_w && st.ov_mode;
      end
      tmcr_pkg::S_SCAN: begin
        cmd.scan_run = !st.hit;
        cmd.set_ov   = hit_w && st.ov_mode;
      end
      tmcr_pkg::S_ADV:    cmd.advance = 1'b1;
      tmcr_pkg::S_AXEND:  cmd.axis_end = 1'b1;
      tmcr_pkg::S_RESULT: cmd.result_load = st.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/tmcr_dp.sv @@
// ----------------------------------------------------------------------------
// tmcr_dp
// Datapath: map registers, solid map RAM, rectangle-to-tile range, range
// cache, tile scan counters, sweep position and result register.
// ----------------------------------------------------------------------------
module tmcr_dp #(
  parameter int MAP_TILES = tmcr_pkg::MAP_TILES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tmcr_pkg::dp_cmd_t                  cmd,
  output tmcr_pkg::dp_stat_t                 st,
  input  logic [tmcr_pkg::CMD_W-1:0]         in_command,
  input  logic [tmcr_pkg::IDX_W-1:0]         in_tile_index,
  input  logic                               in_tile_solid,
  input  logic signed [tmcr_pkg::PX_W-1:0]   in_left_px,
  input  logic signed [tmcr_pkg::PX_W-1:0]   in_top_px,
  input  logic [tmcr_pkg::DIM_W-1:0]         in_width_px,
  input  logic [tmcr_pkg::DIM_W-1:0]         in_height_px,
  input  logic signed [tmcr_pkg::MOVE_W-1:0] in_move_x,
  input  logic signed [tmcr_pkg::MOVE_W-1:0] in_move_y,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [tmcr_pkg::CFG_W-1:0]         cfg_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_overlaps,
  output logic signed [tmcr_pkg::MOVE_W-1:0] out_achieved_x,
  output logic signed [tmcr_pkg::MOVE_W-1:0] out_achieved_y
);

  localparam int AW   = (MAP_TILES > 1) ? $clog2(MAP_TILES) : 1;
  localparam int PX_W = tmcr_pkg::PX_W;
  localparam int TC_W = tmcr_pkg::TC_W;
  localparam int MV_W = tmcr_pkg::MOVE_W;
  localparam int SH   = tmcr_pkg::TILE_SHIFT;
  localparam logic [tmcr_pkg::IDX_W:0] DEPTH_X = (tmcr_pkg::IDX_W+1)'(MAP_TILES);

  // configuration
  logic [tmcr_pkg::CFG_W-1:0] map_w_r, map_h_r;

  // latched item
  logic [tmcr_pkg::CMD_W-1:0]  cmd_r;
  logic [tmcr_pkg::IDX_W-1:0]  idx_r;
  logic                        solid_r;
  logic [PX_W-1:0]             left_r, top_r;
  logic [tmcr_pkg::DIM_W-1:0]  w_r, h_r;
  logic [MV_W-1:0]             dx_r, dy_r;

  // sweep state
  logic [PX_W-1:0] probe_x_r, probe_y_r;
  logic [MV_W-1:0] done_r, ax_r, ay_r;
  logic            axis_y_r;
  logic            ov_r;

  // tile range of the current probe, and the last range found free
  logic [TC_W-1:0] tl_r, tr_r, tt_r, tb_r;
  logic [TC_W-1:0] c_tl_r, c_tr_r, c_tt_r, c_tb_r;
  logic            cache_vld_r;

  // scan counters
  logic [7:0]         col_r, row_r;
  logic [PX_W-1:0]    row_base_r;
  logic               issue_done_r;
  logic               pend_r;
  logic [AW-1:0]      clr_cnt_r;

  // result register
  logic            out_valid_r;
  logic            out_ov_r;
  logic [MV_W-1:0] out_ax_r, out_ay_r;

  // combinational
  logic [MV_W-1:0]        delta;
  logic [MV_W-1:0]        step8;
  logic [PX_W-1:0]        step16;
  logic [PX_W-1:0]        right_px, bottom_px;
  logic signed [TC_W-1:0] mw_ext, mh_ext;
  logic [PX_W-1:0]        rd_addr;
  logic                   rd_en;
  logic                   rd_ok;
  logic                   idx_ok;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [0:0]             ram_wdata;
  logic [0:0]             ram_rdata;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r <= '0;
      map_h_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tmcr_pkg::CFG_MAP_WIDTH:  map_w_r <= cfg_data;
        tmcr_pkg::CFG_MAP_HEIGHT: map_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // step direction of the active axis
  assign delta  = axis_y_r ? dy_r : dx_r;
  assign step8  = delta[MV_W-1] ? {MV_W{1'b1}} : MV_W'(1);
  assign step16 = delta[MV_W-1] ? {PX_W{1'b1}} : PX_W'(1);

  // far edges, wrapping in 16 bits
  assign right_px  = probe_x_r + PX_W'(w_r) - PX_W'(1);
  assign bottom_px = probe_y_r + PX_W'(h_r) - PX_W'(1);

  assign mw_ext = $signed(TC_W'(map_w_r));
  assign mh_ext = $signed(TC_W'(map_h_r));

  // latch item, walk the sweep, take the tile range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_vld_r <= 1'b0;
    end else if (cmd.load) begin
      cache_vld_r <= 1'b0;
    end else if (cmd.advance) begin
      cache_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_command;
      idx_r     <= in_tile_index;
      solid_r   <= in_tile_solid;
      left_r    <= in_left_px;
      top_r     <= in_top_px;
      w_r       <= in_width_px;
      h_r       <= in_height_px;
      dx_r      <= in_move_x;
      dy_r      <= in_move_y;
      probe_x_r <= in_left_px;
      probe_y_r <= in_top_px;
      done_r    <= '0;
      ax_r      <= '0;
      ay_r      <= '0;
      axis_y_r  <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      if (cmd.axis_init) begin
        done_r <= '0;
        if (axis_y_r) probe_y_r <= top_r + step16;
        else          probe_x_r <= left_r + step16;
      end
      if (cmd.advance) begin
        done_r <= done_r + step8;
        if (axis_y_r) probe_y_r <= probe_y_r + step16;
        else          probe_x_r <= probe_x_r + step16;
      end
      if (cmd.axis_end) begin
        if (axis_y_r) begin
          ay_r <= done_r;
        end else begin
          ax_r      <= done_r;
          axis_y_r  <= 1'b1;
          probe_x_r <= left_r + {{(PX_W-MV_W){done_r[MV_W-1]}}, done_r};
        end
      end
      if (cmd.set_ov) ov_r <= 1'b1;
    end
  end

  // floor division by the tile size drops the low bits
  always_ff @(posedge clk) begin
    if (cmd.probe) begin
      tl_r <= probe_x_r[PX_W-1:SH];
      tr_r <= right_px[PX_W-1:SH];
      tt_r <= probe_y_r[PX_W-1:SH];
      tb_r <= bottom_px[PX_W-1:SH];
    end
    if (cmd.advance) begin
      c_tl_r <= tl_r;
      c_tr_r <= tr_r;
      c_tt_r <= tt_r;
      c_tb_r <= tb_r;
    end
  end

  // range checks
  always_comb begin
    st = '0;
    st.clear_done = (clr_cnt_r == AW'(MAP_TILES - 1));
    st.ov_mode    = (cmd_r == tmcr_pkg::CMD_OVERLAP);
    st.axis_y     = axis_y_r;
    st.delta_zero = (delta == '0);
    st.last_step  = ((done_r + step8) == delta);
    st.empty      = (w_r == '0) || (h_r == '0) ||
                    ($signed(tr_r) < $signed(tl_r)) ||
                    ($signed(tb_r) < $signed(tt_r));
    st.outside    = tl_r[TC_W-1] || tt_r[TC_W-1] ||
                    ($signed(tr_r) >= mw_ext) || ($signed(tb_r) >= mh_ext);
    st.cached     = cache_vld_r && (tl_r == c_tl_r) && (tr_r == c_tr_r) &&
                    (tt_r == c_tt_r) && (tb_r == c_tb_r);
    st.hit        = pend_r && ram_rdata[0];
    st.issue_done = issue_done_r;
    st.pend       = pend_r;
    st.out_free   = !out_valid_r || !out_stall;
  end

  // tile scan: one map read per cycle, row by row
  assign rd_addr = row_base_r + PX_W'(col_r);
  assign rd_en   = cmd.scan_run && !issue_done_r;
  assign rd_ok   = ({1'b0, rd_addr} < DEPTH_X);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_done_r <= 1'b1;
      pend_r       <= 1'b0;
    end else begin
      pend_r <= rd_en && rd_ok;
      if (cmd.scan_load) begin
        issue_done_r <= 1'b0;
      end else if (rd_en && (col_r == tr_r[7:0]) && (row_r == tb_r[7:0])) begin
        issue_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_load) begin
      col_r      <= tl_r[7:0];
      row_r      <= tt_r[7:0];
      row_base_r <= PX_W'(tt_r[7:0]) * PX_W'(map_w_r);
    end else if (rd_en) begin
      if (col_r == tr_r[7:0]) begin
        col_r      <= tl_r[7:0];
        row_r      <= row_r + 8'd1;
        row_base_r <= row_base_r + PX_W'(map_w_r);
      end else begin
        col_r <= col_r + 8'd1;
      end
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_run) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // map write: clearing pass or tile write in range
  assign idx_ok    = ({1'b0, idx_r} < DEPTH_X);
  assign ram_we    = cmd.clear_run || (cmd.mem_write && idx_ok);
  assign ram_waddr = cmd.clear_run ? clr_cnt_r : idx_r[AW-1:0];
  assign ram_wdata = cmd.clear_run ? 1'b0 : solid_r;

  tmcr_ram #(
    .WIDTH (1),
    .DEPTH (MAP_TILES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  // result word: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_ov_r <= ov_r;
      out_ax_r <= ax_r;
      out_ay_r <= ay_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_overlaps   = out_ov_r;
  assign out_achieved_x = out_ax_r;
  assign out_achieved_y = out_ay_r;

endmodule
